[sv/pcd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcd_pkg: shared types and constants
// Widths, command and status records, and the product schedule of the
// periodic circumcenter de-duplication block.
// ----------------------------------------------------------------------------
package pcd_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int IDXW = $clog2(MAX_VERTICES);
  localparam int CNTW = $clog2(MAX_VERTICES + 1);

  localparam int CW = 32;          // coordinate width
  localparam int PW = 34;          // unwrapped point width
  localparam int DW = 36;          // point difference width
  localparam int WW = 128;         // wide accumulator width
  localparam int MUL_STEPS = DW;
  localparam int DIV_STEPS = WW;
  localparam int STEPW = $clog2(DIV_STEPS);
  localparam int QCAPW = 41;       // quotient magnitude cap is 2^(QCAPW-1)
  localparam int NUM_PROD = 10;
  localparam int PRODW = $clog2(NUM_PROD);
  localparam int CFG_IDXW = 2;
  localparam int TOLW = 16;
  localparam int BOXW = 31;

  // First product after the determinant is complete.
  localparam logic [PRODW-1:0] PROD_SA_START = PRODW'(2);
  localparam logic [PRODW-1:0] PROD_LAST = PRODW'(NUM_PROD - 1);

  typedef enum logic [CFG_IDXW-1:0] {
    CFG_BOX_WIDTH  = 2'd0,
    CFG_BOX_HEIGHT = 2'd1,
    CFG_TOLERANCE  = 2'd2
  } cfg_e;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_COLLINEAR = 2'd1,
    STS_FULL      = 2'd2,
    STS_SAT       = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_UNWRAP2, ST_UNWRAP3, ST_DIFF, ST_MUL_INIT, ST_MUL_RUN,
    ST_MUL_END, ST_DIV_INIT, ST_DIV_RUN, ST_DIV_END, ST_SCAN_RD, ST_SCAN_CMP,
    ST_COMMIT, ST_FINISH
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_UNWRAP2, OP_UNWRAP3, OP_DIFF, OP_MUL_INIT,
    OP_MUL_STEP, OP_MUL_END, OP_DIV_INIT, OP_DIV_STEP, OP_DIV_END,
    OP_SCAN_RD, OP_SCAN_CMP, OP_COMMIT, OP_PUBLISH
  } op_e;

  typedef enum logic [1:0] {A_AX, A_AY, A_BX, A_BY} asel_e;
  typedef enum logic [2:0] {B_AX, B_AY, B_BX, B_BY, B_SA, B_SB} bsel_e;
  typedef enum logic [2:0] {D_NONE, D_DET, D_SA, D_SB, D_NX, D_NY} dest_e;

  typedef struct packed {
    asel_e a;
    bsel_e b;
    logic  neg;
    logic  clr;
    dest_e dest;
  } prod_t;

  typedef struct packed {
    op_e              op;
    logic [PRODW-1:0] prod;
    logic             last;
    logic             div_y;
    logic [IDXW-1:0]  addr;
  } cmd_t;

  typedef struct packed {
    logic            det_zero;
    logic            sat;
    logic            hit;
    logic            out_busy;
    logic [CNTW-1:0] count;
  } sts_t;

  typedef struct packed {
    logic signed [CW-1:0] first_x;
    logic signed [CW-1:0] first_y;
    logic signed [CW-1:0] second_x;
    logic signed [CW-1:0] second_y;
    logic signed [CW-1:0] third_x;
    logic signed [CW-1:0] third_y;
    logic                 new_cell;
  } item_t;

  typedef struct packed {
    logic signed [CW-1:0] center_x;
    logic signed [CW-1:0] center_y;
    logic                 is_new;
    status_e              status;
  } result_t;

  // Products for det = 2(ax*by - ay*bx), sa, sb, nx = by*sa - ay*sb and
  // ny = ax*sb - bx*sa, accumulated two at a time.
  function automatic prod_t prod_info(logic [PRODW-1:0] k);
    prod_t p;
    p = '{a: A_AX, b: B_BY, neg: 1'b0, clr: 1'b1, dest: D_NONE};
    case (k)
      4'd0: p = '{a: A_AX, b: B_BY, neg: 1'b0, clr: 1'b1, dest: D_NONE};
      4'd1: p = '{a: A_AY, b: B_BX, neg: 1'b1, clr: 1'b0, dest: D_DET};
      4'd2: p = '{a: A_AX, b: B_AX, neg: 1'b0, clr: 1'b1, dest: D_NONE};
      4'd3: p = '{a: A_AY, b: B_AY, neg: 1'b0, clr: 1'b0, dest: D_SA};
      4'd4: p = '{a: A_BX, b: B_BX, neg: 1'b0, clr: 1'b1, dest: D_NONE};
      4'd5: p = '{a: A_BY, b: B_BY, neg: 1'b0, clr: 1'b0, dest: D_SB};
      4'd6: p = '{a: A_BY, b: B_SA, neg: 1'b0, clr: 1'b1, dest: D_NONE};
      4'd7: p = '{a: A_AY, b: B_SB, neg: 1'b1, clr: 1'b0, dest: D_NX};
      4'd8: p = '{a: A_AX, b: B_SB, neg: 1'b0, clr: 1'b1, dest: D_NONE};
      4'd9: p = '{a: A_BX, b: B_SA, neg: 1'b1, clr: 1'b0, dest: D_NY};
      default: p = '{a: A_AX, b: B_AX, neg: 1'b0, clr: 1'b1, dest: D_NONE};
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

[sv/pcd_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcd_if: channel interfaces
// Input triple, result and configuration write channels, valid/ready.
// ----------------------------------------------------------------------------
interface pcd_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] first_x;
  logic signed [31:0] first_y;
  logic signed [31:0] second_x;
  logic signed [31:0] second_y;
  logic signed [31:0] third_x;
  logic signed [31:0] third_y;
  logic               new_cell;
  modport source(output valid, first_x, first_y, second_x, second_y, third_x,
                 third_y, new_cell, input ready);
  modport sink(input valid, first_x, first_y, second_x, second_y, third_x,
               third_y, new_cell, output ready);
  modport monitor(input valid, first_x, first_y, second_x, second_y, third_x,
                  third_y, new_cell, ready);
endinterface

interface pcd_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] center_x;
  logic signed [31:0] center_y;
  logic               is_new;
  logic [1:0]         status;
  modport source(output valid, center_x, center_y, is_new, status, input ready);
  modport sink(input valid, center_x, center_y, is_new, status, output ready);
  modport monitor(input valid, center_x, center_y, is_new, status, ready);
endinterface

interface pcd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
  modport monitor(input valid, index, data, ready);
endinterface
`default_nettype wire

[sv/pcd_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcd_ctrl: sequencer
// Steps the datapath through unwrap, products, divisions and the set scan.
// ----------------------------------------------------------------------------
module pcd_ctrl import pcd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e           state_q, state_d;
  logic [STEPW-1:0] step_q, step_d;
  logic [PRODW-1:0] prod_q, prod_d;
  logic             divy_q, divy_d;
  logic [CNTW-1:0]  idx_q, idx_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      prod_q  <= '0;
      divy_q  <= 1'b0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      prod_q  <= prod_d;
      divy_q  <= divy_d;
      idx_q   <= idx_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    prod_d     = prod_q;
    divy_d     = divy_q;
    idx_d      = idx_q;
    in_ready_o = 1'b0;
    cmd_o      = '{op: OP_NONE, prod: prod_q, last: 1'b0, div_y: divy_q,
                   addr: idx_q[IDXW-1:0]};
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = ST_UNWRAP2;
        end
      end
      ST_UNWRAP2: begin
        cmd_o.op = OP_UNWRAP2;
        state_d  = ST_UNWRAP3;
      end
      ST_UNWRAP3: begin
        cmd_o.op = OP_UNWRAP3;
        state_d  = ST_DIFF;
      end
      ST_DIFF: begin
        cmd_o.op = OP_DIFF;
        prod_d   = '0;
        state_d  = ST_MUL_INIT;
      end
      ST_MUL_INIT: begin
        // A zero determinant ends the item as collinear.
        if (prod_q == PROD_SA_START && sts_i.det_zero) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.op = OP_MUL_INIT;
          step_d   = '0;
          state_d  = ST_MUL_RUN;
        end
      end
      ST_MUL_RUN: begin
        cmd_o.op   = OP_MUL_STEP;
        cmd_o.last = (step_q == STEPW'(MUL_STEPS - 1));
        step_d     = step_q + 1'b1;
        if (cmd_o.last) begin
          state_d = ST_MUL_END;
        end
      end
      ST_MUL_END: begin
        cmd_o.op = OP_MUL_END;
        if (prod_q == PROD_LAST) begin
          divy_d  = 1'b0;
          state_d = ST_DIV_INIT;
        end else begin
          prod_d  = prod_q + 1'b1;
          state_d = ST_MUL_INIT;
        end
      end
      ST_DIV_INIT: begin
        cmd_o.op = OP_DIV_INIT;
        step_d   = '0;
        state_d  = ST_DIV_RUN;
      end
      ST_DIV_RUN: begin
        cmd_o.op = OP_DIV_STEP;
        step_d   = step_q + 1'b1;
        if (step_q == STEPW'(DIV_STEPS - 1)) begin
          state_d = ST_DIV_END;
        end
      end
      ST_DIV_END: begin
        cmd_o.op = OP_DIV_END;
        if (!divy_q) begin
          divy_d  = 1'b1;
          state_d = ST_DIV_INIT;
        end else begin
          idx_d   = '0;
          state_d = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: begin
        if (sts_i.sat) begin
          state_d = ST_FINISH;
        end else if (idx_q == sts_i.count) begin
          state_d = ST_COMMIT;
        end else begin
          cmd_o.op = OP_SCAN_RD;
          state_d  = ST_SCAN_CMP;
        end
      end
      ST_SCAN_CMP: begin
        cmd_o.op = OP_SCAN_CMP;
        if (sts_i.hit) begin
          state_d = ST_FINISH;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_SCAN_RD;
        end
      end
      ST_COMMIT: begin
        cmd_o.op = OP_COMMIT;
        state_d  = ST_FINISH;
      end
      ST_FINISH: begin
        if (!sts_i.out_busy) begin
          cmd_o.op = OP_PUBLISH;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

[sv/pcd_dpath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcd_dpath: datapath
// Configuration, unwrap, shift-add multiplier, restoring divider, vertex
// store and the output register.
// ----------------------------------------------------------------------------
module pcd_dpath import pcd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  input  item_t               item_i,
  input  logic                cfg_we_i,
  input  logic [CFG_IDXW-1:0] cfg_idx_i,
  input  logic [31:0]         cfg_data_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output result_t             result_o
);

  logic [BOXW-1:0] box_w_q, box_h_q;
  logic [TOLW-1:0] tol_q;

  logic signed [CW-1:0] x1_q, y1_q, vx_q, vy_q;
  logic signed [PW-1:0] x2_q, y2_q, x3_q, y3_q;
  logic signed [DW-1:0] ax_q, ay_q, bx_q, by_q, a_sh_q;
  logic [WW-1:0] acc_q, b_sh_q, det_q, sa_q, sb_q, nx_q, ny_q;
  logic [WW-1:0] n_sh_q, d_mag_q, rem_q, quo_q;
  logic          qneg_q, sat_q, new_q, full_q;
  logic [CNTW-1:0] count_q;
  logic signed [CW-1:0] mem_x [MAX_VERTICES];
  logic signed [CW-1:0] mem_y [MAX_VERTICES];
  logic signed [CW-1:0] rd_x_q, rd_y_q;
  logic    out_valid_q;
  result_t out_q;

  prod_t                p;
  logic signed [DW-1:0] a_op;
  logic [WW-1:0]        b_op, addend, num, trial_low;
  logic [WW:0]          trial;
  logic                 ge;
  logic [QCAPW-1:0]     qmag;
  logic signed [QCAPW+1:0] vsum;
  logic signed [CW-1:0] base, vclamp;
  logic                 vsat;
  logic signed [CW:0]   dx, dy, adx, ady;
  logic                 hit;

  function automatic logic signed [PW-1:0] unwrap(logic signed [PW-1:0] pt,
                                                  logic signed [PW-1:0] ref_pt,
                                                  logic [BOXW-1:0] len);
    logic signed [PW+2:0] pp, rr, ll, d2;
    pp = {{3{pt[PW-1]}}, pt};
    rr = {{3{ref_pt[PW-1]}}, ref_pt};
    ll = $signed({{(PW+3-BOXW){1'b0}}, len});
    d2 = (pp - rr) <<< 1;
    if (d2 > ll) pp = pp - ll;
    d2 = (pp - rr) <<< 1;
    if (d2 < -ll) pp = pp + ll;
    return pp[PW-1:0];
  endfunction

  function automatic logic signed [PW-1:0] ext_pt(logic signed [CW-1:0] v);
    return {{(PW-CW){v[CW-1]}}, v};
  endfunction

  function automatic logic [WW-1:0] ext_wide(logic signed [DW-1:0] v);
    return {{(WW-DW){v[DW-1]}}, v};
  endfunction

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_w_q <= BOXW'(65536);
      box_h_q <= BOXW'(65536);
      tol_q   <= TOLW'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BOX_WIDTH:  box_w_q <= cfg_data_i[BOXW-1:0];
        CFG_BOX_HEIGHT: box_h_q <= cfg_data_i[BOXW-1:0];
        CFG_TOLERANCE:  tol_q   <= cfg_data_i[TOLW-1:0];
        default: ;
      endcase
    end
  end

  // Operand selection and step arithmetic.
  always_comb begin
    p = prod_info(cmd_i.prod);
    case (p.a)
      A_AX: a_op = ax_q;
      A_AY: a_op = ay_q;
      A_BX: a_op = bx_q;
      A_BY: a_op = by_q;
      default: a_op = ax_q;
    endcase
    case (p.b)
      B_AX: b_op = ext_wide(ax_q);
      B_AY: b_op = ext_wide(ay_q);
      B_BX: b_op = ext_wide(bx_q);
      B_BY: b_op = ext_wide(by_q);
      B_SA: b_op = sa_q;
      B_SB: b_op = sb_q;
      default: b_op = sa_q;
    endcase
    // The top bit of the signed multiplier carries negative weight.
    addend    = cmd_i.last ? (~b_sh_q + 1'b1) : b_sh_q;
    num       = cmd_i.div_y ? ny_q : nx_q;
    trial     = {rem_q, n_sh_q[WW-1]};
    ge        = trial >= {1'b0, d_mag_q};
    trial_low = WW'(trial - {1'b0, d_mag_q});
    qmag      = (quo_q > (WW'(1) << (QCAPW - 1))) ? {1'b1, {(QCAPW-1){1'b0}}}
                                                 : quo_q[QCAPW-1:0];
    base      = cmd_i.div_y ? y1_q : x1_q;
    vsum      = {{2{base[CW-1]}}, {(QCAPW-CW){base[CW-1]}}, base}
              + (qneg_q ? -$signed({2'b00, qmag}) : $signed({2'b00, qmag}));
    vsat      = 1'b0;
    vclamp    = vsum[CW-1:0];
    if (vsum > $signed((QCAPW+2)'(32'sh7fffffff))) begin
      vsat   = 1'b1;
      vclamp = 32'sh7fffffff;
    end else if (vsum < -$signed((QCAPW+2)'(33'h080000000))) begin
      vsat   = 1'b1;
      vclamp = 32'sh80000000;
    end
    dx  = {vx_q[CW-1], vx_q} - {rd_x_q[CW-1], rd_x_q};
    dy  = {vy_q[CW-1], vy_q} - {rd_y_q[CW-1], rd_y_q};
    adx = dx[CW] ? -dx : dx;
    ady = dy[CW] ? -dy : dy;
    hit = ($unsigned(adx) < {{(CW+1-TOLW){1'b0}}, tol_q})
       && ($unsigned(ady) < {{(CW+1-TOLW){1'b0}}, tol_q});
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        x1_q <= item_i.first_x;
        y1_q <= item_i.first_y;
        x2_q <= ext_pt(item_i.second_x);
        y2_q <= ext_pt(item_i.second_y);
        x3_q <= ext_pt(item_i.third_x);
        y3_q <= ext_pt(item_i.third_y);
      end
      OP_UNWRAP2: begin
        x2_q <= unwrap(x2_q, ext_pt(x1_q), box_w_q);
        y2_q <= unwrap(y2_q, ext_pt(y1_q), box_h_q);
      end
      OP_UNWRAP3: begin
        x3_q <= unwrap(x3_q, x2_q, box_w_q);
        y3_q <= unwrap(y3_q, y2_q, box_h_q);
      end
      OP_DIFF: begin
        ax_q <= DW'(x2_q) - DW'(ext_pt(x1_q));
        ay_q <= DW'(y2_q) - DW'(ext_pt(y1_q));
        bx_q <= DW'(x3_q) - DW'(ext_pt(x1_q));
        by_q <= DW'(y3_q) - DW'(ext_pt(y1_q));
      end
      OP_MUL_INIT: begin
        if (p.clr) acc_q <= '0;
        a_sh_q <= a_op;
        b_sh_q <= p.neg ? (~b_op + 1'b1) : b_op;
      end
      OP_MUL_STEP: begin
        if (a_sh_q[0]) acc_q <= acc_q + addend;
        a_sh_q <= a_sh_q >>> 1;
        b_sh_q <= b_sh_q << 1;
      end
      OP_MUL_END: begin
        case (p.dest)
          D_DET:   det_q <= acc_q << 1;
          D_SA:    sa_q  <= acc_q;
          D_SB:    sb_q  <= acc_q;
          D_NX:    nx_q  <= acc_q;
          D_NY:    ny_q  <= acc_q;
          default: ;
        endcase
      end
      OP_DIV_INIT: begin
        n_sh_q  <= num[WW-1] ? (~num + 1'b1) : num;
        d_mag_q <= det_q[WW-1] ? (~det_q + 1'b1) : det_q;
        qneg_q  <= num[WW-1] ^ det_q[WW-1];
        rem_q   <= '0;
        quo_q   <= '0;
      end
      OP_DIV_STEP: begin
        rem_q  <= ge ? trial_low : trial[WW-1:0];
        quo_q  <= {quo_q[WW-2:0], ge};
        n_sh_q <= n_sh_q << 1;
      end
      OP_DIV_END: begin
        if (cmd_i.div_y) vy_q <= vclamp;
        else vx_q <= vclamp;
      end
      default: ;
    endcase
  end

  // Vertex store, written at the fill count and read one entry per scan step.
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_COMMIT && count_q < CNTW'(MAX_VERTICES)) begin
      mem_x[count_q[IDXW-1:0]] <= vx_q;
      mem_y[count_q[IDXW-1:0]] <= vy_q;
    end
    if (cmd_i.op == OP_SCAN_RD) begin
      rd_x_q <= mem_x[cmd_i.addr];
      rd_y_q <= mem_y[cmd_i.addr];
    end
  end

  // Control flags, fill count and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      sat_q       <= 1'b0;
      new_q       <= 1'b0;
      full_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (cmd_i.op)
        OP_LOAD: begin
          if (item_i.new_cell) count_q <= '0;
          sat_q  <= 1'b0;
          new_q  <= 1'b0;
          full_q <= 1'b0;
        end
        OP_DIV_END: if (vsat) sat_q <= 1'b1;
        OP_COMMIT: begin
          if (count_q < CNTW'(MAX_VERTICES)) begin
            count_q <= count_q + 1'b1;
            new_q   <= 1'b1;
          end else begin
            full_q <= 1'b1;
          end
        end
        OP_PUBLISH: out_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_PUBLISH) begin
      if (sts_o.det_zero) begin
        out_q <= '{center_x: '0, center_y: '0, is_new: 1'b0,
                   status: STS_COLLINEAR};
      end else begin
        out_q.center_x <= vx_q;
        out_q.center_y <= vy_q;
        out_q.is_new   <= new_q;
        out_q.status   <= sat_q ? STS_SAT : (full_q ? STS_FULL : STS_OK);
      end
    end
  end

  assign sts_o = '{det_zero: (det_q == '0), sat: sat_q, hit: hit,
                   out_busy: out_valid_q, count: count_q};
  assign out_valid_o = out_valid_q;
  assign result_o    = out_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNTW'(MAX_VERTICES))
    else $error("vertex count beyond capacity");
  a_commit_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_COMMIT) |-> (!sat_q && det_q != '0))
    else $error("commit of a saturated or collinear vertex");
  a_publish_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.op == OP_PUBLISH))
    else $error("result shown without publish");
  a_new_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.is_new) |-> (out_q.status == STS_OK))
    else $error("new vertex with error status");
`endif

endmodule
`default_nettype wire

[sv/periodic_circumcenter_dedup.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_circumcenter_dedup: periodic circumcenter with vertex de-duplication
// Unwraps three points into one periodic image, computes their circumcenter
// and keeps a per-cell set of distinct vertices.
// ----------------------------------------------------------------------------
// Usage. A triple arrives as one beat on items_i; the new_cell bit empties the
// vertex set before the triple is handled. Each triple yields exactly one beat
// on results_o with the saturated circumcenter, an is_new flag and a status.
// Registers (box width, box height, tolerance) are written through cfg_i,
// which is always ready; write them only while no triple is in flight.
// Sequence. The work runs on one shift-add multiplier (ten products) and one
// restoring divider (two quotients); the set scan then compares the stored
// vertices in turn until a match. A collinear triple ends once its determinant
// is known.
// One triple is worked on at a time, and items_i is ready only when idle.
// The result sits in an output register, so the next triple is accepted
// while an earlier result waits; if the receiver stalls, the following
// result waits until that register is free.
// Reset clears the control state, the fill count of the vertex set and the
// output valid, and returns the registers to their defaults. The vertex
// store itself is not cleared; entries past the fill count are never read.
// ----------------------------------------------------------------------------
module periodic_circumcenter_dedup import pcd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  pcd_in_if.sink     items_i,
  pcd_out_if.source  results_o,
  pcd_cfg_if.sink    cfg_i
);

  cmd_t    cmd;
  sts_t    sts;
  item_t   item;
  result_t result;
  logic    in_ready;
  logic    out_valid;

  // Configuration never stalls.
  assign cfg_i.ready = 1'b1;

  assign item = '{first_x: items_i.first_x, first_y: items_i.first_y,
                  second_x: items_i.second_x, second_y: items_i.second_y,
                  third_x: items_i.third_x, third_y: items_i.third_y,
                  new_cell: items_i.new_cell};
  assign items_i.ready = in_ready;

  pcd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (items_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pcd_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .item_i      (item),
    .cfg_we_i    (cfg_i.valid),
    .cfg_idx_i   (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .out_ready_i (results_o.ready),
    .out_valid_o (out_valid),
    .result_o    (result)
  );

  // The output register drives the result channel directly.
  assign results_o.valid    = out_valid;
  assign results_o.center_x = result.center_x;
  assign results_o.center_y = result.center_y;
  assign results_o.is_new   = result.is_new;
  assign results_o.status   = result.status;

endmodule
`default_nettype wire
